// ===== hw/rtl/chash_pkg.sv =====
// shared constants, types and codes of the chained hash table
`default_nettype none
package chash_pkg;

  localparam int BUCKETS = 64;
  localparam int NODES   = 256;

  localparam int KEY_W  = 31;
  localparam int PAY_W  = 64;
  localparam int BC_W   = 7;
  localparam int DIV_W  = BC_W;
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PTR_W  = $clog2(NODES + 1);
  localparam int CNT_W  = $clog2(KEY_W + 1);
  localparam int DATA_W = ((KEY_W + PAY_W + 7) / 8) * 8;

  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NODES);
  localparam logic [BC_W-1:0]  BC_RESET = BC_W'(13);

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_FIND   = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [PTR_W-1:0]  link;
  } node_wr_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [PTR_W-1:0] link;
  } node_rd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/chained_hash_table.sv =====
// chained hash table top level: request handshake, sequencer and result register
// an insert passes from accept to result through the bit-serial modulo unit, the
// head read, the node write and the result load
// a find takes the same steps but walks the chain, if any, in place of the write (one link read per cycle)
// one request in flight; the next is taken the cycle after the result loads, and a
// result still held on the output stalls the load
// rst (synchronous) empties all buckets, clears the pool and sets bucket_count to 13
`default_nettype none
module chained_hash_table
  import chash_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // request side
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,   // key [30:0], payload_in [94:31], zero pad
  input  wire logic              s_tuser,   // req_type
  // result side
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DATA_W-1:0]      m_tdata,   // key_out [30:0], payload_out [94:31], zero pad
  output logic [1:0]             m_tuser,   // status
  // bucket count register
  input  wire logic              cfg_wr_en,
  input  wire logic [BC_W-1:0]   cfg_wr_data
);

  state_t state, state_next;

  logic [BC_W-1:0]  bucket_count;
  logic [DIV_W-1:0] divisor;

  // latched request
  req_t             req_type;
  logic [KEY_W-1:0] req_key;
  logic [PAY_W-1:0] req_payload;
  logic [BKT_W-1:0] bucket;

  // pool fill count, NODES means exhausted
  logic [PTR_W-1:0] nodes_used, nodes_used_next;

  // result waiting for the output register
  status_t          res_status, res_status_next;
  logic [PAY_W-1:0] res_payload, res_payload_next;

  logic             accept;
  logic             mod_done;
  logic [DIV_W-1:0] mod_rem;
  logic [PTR_W-1:0] head;
  logic             head_wr_en;
  logic             node_wr_en;
  node_wr_t         node_wr;
  node_rd_t         node_rd;
  logic [NODE_W-1:0] node_rd_addr;
  logic             out_load;

  assign accept = s_tvalid && s_tready;

  // zero counts as one bucket, anything above the table size saturates
  always_comb begin
    if (bucket_count == '0) begin
      divisor = DIV_W'(1);
    end else if (int'(bucket_count) > BUCKETS) begin
      divisor = DIV_W'(BUCKETS);
    end else begin
      divisor = bucket_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BC_RESET;
    end else if (cfg_wr_en) begin
      bucket_count <= cfg_wr_data;
    end
  end

  chash_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .key     (s_tdata[KEY_W-1:0]),
    .divisor (divisor),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // head read is issued as the remainder comes out, data shows up in S_HEAD
  chash_head_mem u_head (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (BKT_W'(mod_rem)),
    .wr_en   (head_wr_en),
    .wr_addr (bucket),
    .wr_data (nodes_used),
    .rd_data (head)
  );

  chash_node_mem u_node (
    .clk     (clk),
    .wr      (node_wr),
    .rd_addr (node_rd_addr),
    .rd      (node_rd)
  );

  // walk starts at the bucket head, then follows the link just read
  assign node_rd_addr = (state == S_HEAD) ? head[NODE_W-1:0] : node_rd.link[NODE_W-1:0];

  // new node goes to the head of the chain and points at the old head
  assign node_wr.en      = node_wr_en;
  assign node_wr.addr    = nodes_used[NODE_W-1:0];
  assign node_wr.key     = req_key;
  assign node_wr.payload = req_payload;
  assign node_wr.link    = head;

  always_comb begin
    state_next       = state;
    nodes_used_next  = nodes_used;
    res_status_next  = res_status;
    res_payload_next = res_payload;
    head_wr_en       = 1'b0;
    node_wr_en       = 1'b0;
    s_tready         = 1'b0;
    out_load         = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        res_payload_next = '0;
        if (req_type == REQ_INSERT) begin
          state_next = S_DONE;
          if (nodes_used == NULL_PTR) begin
            res_status_next = ST_FULL;
          end else begin
            node_wr_en      = 1'b1;
            head_wr_en      = 1'b1;
            nodes_used_next = nodes_used + 1'b1;
            res_status_next = ST_INSERTED;
          end
        end else if (head == NULL_PTR) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end else begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        // one node per cycle, first match is the newest insert of the key
        if (node_rd.key == req_key) begin
          res_status_next  = ST_FOUND;
          res_payload_next = node_rd.payload;
          state_next       = S_DONE;
        end else if (node_rd.link == NULL_PTR) begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      nodes_used <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      nodes_used <= nodes_used_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_type    <= req_t'(s_tuser);
      req_key     <= s_tdata[KEY_W-1:0];
      req_payload <= s_tdata[KEY_W+PAY_W-1:KEY_W];
    end
    if (mod_done) begin
      bucket <= BKT_W'(mod_rem);
    end
    res_status  <= res_status_next;
    res_payload <= res_payload_next;
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= DATA_W'({res_payload, req_key});
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/chash_mod.sv =====
// iterative restoring modulo unit, one key bit per cycle
`default_nettype none
module chash_mod
  import chash_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] key,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      rem
);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] key_sh;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  assign trial = {rem, key_sh[KEY_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(KEY_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_sh <= key;
      dvs    <= divisor;
      rem    <= '0;
    end else if (busy) begin
      key_sh <= key_sh << 1;
      // remainder stays below the divisor, so the difference fits
      if (trial >= {1'b0, dvs}) begin
        rem <= diff[DIV_W-1:0];
      end else begin
        rem <= trial[DIV_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/chash_node_mem.sv =====
// node pool memory: key, payload and link, one write and one registered read
`default_nettype none
module chash_node_mem
  import chash_pkg::*;
(
  input  wire logic              clk,
  input  wire node_wr_t          wr,
  input  wire logic [NODE_W-1:0] rd_addr,
  output node_rd_t               rd
);

  node_rd_t mem [NODES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= '{key: wr.key, payload: wr.payload, link: wr.link};
    end
    rd <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/chash_head_mem.sv =====
// bucket head memory with per-bucket valid bits, empty buckets read as null
`default_nettype none
module chash_head_mem
  import chash_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [BKT_W-1:0] rd_addr,
  input  wire logic             wr_en,
  input  wire logic [BKT_W-1:0] wr_addr,
  input  wire logic [PTR_W-1:0] wr_data,
  output logic [PTR_W-1:0]      rd_data
);

  logic [PTR_W-1:0] mem [BUCKETS];
  logic [BUCKETS-1:0] valid;
  logic [PTR_W-1:0] data_q;
  logic             valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    data_q <= mem[rd_addr];
  end

  assign rd_data = valid_q ? data_q : NULL_PTR;

endmodule
`default_nettype wire

// ===== bench/tb_chained_hash_table.sv =====
// testbench for the chained hash table: directed table, random traffic, predictor and checker
`timescale 1ns / 100ps
`default_nettype none
module tb_chained_hash_table;
  import chash_pkg::*;

  // one result as the block returns it
  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } table_result_t;

  // one row of the directed table; checked rows carry their result typed in,
  // the others are checked against the predictor
  typedef struct packed {
    req_t             op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             checked;
    status_t          exp_status;
    logic [PAY_W-1:0] exp_payload;
  } request_row_t;

  localparam int DIRECTED_ROWS = 19;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 200;
  localparam int PRINT_LIMIT   = 50;
  localparam logic [KEY_W-1:0] KEY_MAX  = {KEY_W{1'b1}};
  localparam logic [PAY_W-1:0] PAY_ONES = {PAY_W{1'b1}};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;    // key [30:0], payload_in [94:31], zero pad
  logic              s_tuser = 1'b0;  // req_type
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;         // key_out [30:0], payload_out [94:31], zero pad
  logic [1:0]        m_tuser;         // status
  logic              cfg_wr_en = 1'b0;
  logic [BC_W-1:0]   cfg_wr_data = '0;

  // predictor copy of the table
  logic [BC_W-1:0]   bucket_count_reg;
  logic [PTR_W-1:0]  chain_head [BUCKETS];
  logic [KEY_W-1:0]  pool_key [NODES];
  logic [PAY_W-1:0]  pool_payload [NODES];
  logic [PTR_W-1:0]  pool_link [NODES];
  int unsigned       pool_used;

  // results still owed by the block, oldest first
  table_result_t     expected_results [$];
  // keys that made it into the pool, used to aim finds and collisions
  logic [KEY_W-1:0]  stored_keys [$];
  int unsigned       mismatch_count = 0;
  bit                tx_steady = 1'b0;
  bit                rx_steady = 1'b0;

  request_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty table right after reset, both key extremes
    '{REQ_FIND,   31'd0,          64'd0,    1'b1, ST_NOT_FOUND, 64'd0},
    '{REQ_FIND,   KEY_MAX,        PAY_ONES, 1'b1, ST_NOT_FOUND, 64'd0},
    // payload extremes stored and read back
    '{REQ_INSERT, 31'd0,          64'd0,    1'b1, ST_INSERTED,  64'd0},
    '{REQ_INSERT, KEY_MAX,        PAY_ONES, 1'b1, ST_INSERTED,  64'd0},
    '{REQ_FIND,   31'd0,          PAY_ONES, 1'b1, ST_FOUND,     64'd0},
    '{REQ_FIND,   KEY_MAX,        64'd0,    1'b1, ST_FOUND,     PAY_ONES},
    // collisions in bucket zero build a chain of three
    '{REQ_INSERT, 31'd13, 64'h0123_4567_89AB_CDEF, 1'b1, ST_INSERTED, 64'd0},
    '{REQ_INSERT, 31'd26, 64'hFEDC_BA98_7654_3210, 1'b1, ST_INSERTED, 64'd0},
    '{REQ_FIND,   31'd13,         64'd0,    1'b0, ST_FOUND,     64'd0},
    // walk to the tail of the chain, then past it
    '{REQ_FIND,   31'd0,          64'd0,    1'b0, ST_FOUND,     64'd0},
    '{REQ_FIND,   31'd39,         64'd0,    1'b0, ST_FOUND,     64'd0},
    // duplicate key: the newest insert wins
    '{REQ_INSERT, 31'd13, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_INSERTED, 64'd0},
    '{REQ_FIND,   31'd13,         64'd0,    1'b0, ST_FOUND,     64'd0},
    // last bucket in use, then a find of KEY_MAX - 1 in another bucket
    '{REQ_INSERT, 31'd12, 64'h5555_5555_5555_5555, 1'b1, ST_INSERTED, 64'd0},
    '{REQ_FIND,   31'd12,         64'd0,    1'b0, ST_FOUND,     64'd0},
    '{REQ_FIND,   31'd25,         64'd0,    1'b0, ST_FOUND,     64'd0},
    '{REQ_FIND,   KEY_MAX - 31'd1, 64'd0,   1'b0, ST_FOUND,     64'd0},
    // alternating key bits, payload with only its top and bottom bits set
    '{REQ_INSERT, 31'h2AAA_AAAA, 64'h8000_0000_0000_0001, 1'b1, ST_INSERTED, 64'd0},
    '{REQ_FIND,   31'h2AAA_AAAA, 64'd0,     1'b0, ST_FOUND,     64'd0}
  };

  chained_hash_table i_dut (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // divisor actually used: zero acts as one, large values clamp to the table size BUCKETS
  function automatic int unsigned effective_divisor();
    if (bucket_count_reg == '0) begin
      return 1;
    end
    if (int'(bucket_count_reg) > BUCKETS) begin
      return BUCKETS;
    end
    return int'(bucket_count_reg);
  endfunction

  // applies one request to the predictor copy and returns its result
  function automatic table_result_t hash_table_apply(req_t op, logic [KEY_W-1:0] k,
                                                     logic [PAY_W-1:0] pay);
    table_result_t r;
    int unsigned   bucket;
    int unsigned   steps;
    logic [PTR_W-1:0] p;
    bucket    = k % effective_divisor();
    r.key     = k;
    r.payload = '0;
    if (op == REQ_INSERT) begin
      if (pool_used >= NODES) begin
        // pool exhausted, nothing changes
        r.status = ST_FULL;
      end else begin
        pool_key[pool_used]     = k;
        pool_payload[pool_used] = pay;
        pool_link[pool_used]    = chain_head[bucket];
        chain_head[bucket]      = PTR_W'(pool_used);
        pool_used++;
        r.status = ST_INSERTED;
      end
    end else begin
      // walk from the head, first match is the newest insert of the key
      r.status = ST_NOT_FOUND;
      p        = chain_head[bucket];
      steps    = 0;
      while (p != NULL_PTR && steps < NODES) begin
        if (pool_key[p] == k) begin
          r.status  = ST_FOUND;
          r.payload = pool_payload[p];
          break;
        end
        p = pool_link[p];
        steps++;
      end
    end
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    if (steady) begin
      return 0;
    end
    roll = $urandom_range(0, 9);
    if (roll < 4) begin
      return 0;
    end
    if (roll < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // key for a random request: stored keys, bucket mates of them, or fresh ones
  function automatic logic [KEY_W-1:0] pick_key(bit for_find);
    int unsigned      roll;
    logic [KEY_W-1:0] base;
    roll = $urandom_range(0, 99);
    if (stored_keys.size() == 0) begin
      return KEY_W'($urandom);
    end
    base = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    if (for_find ? roll < 70 : roll < 20) begin
      return base;
    end
    if (for_find ? roll < 85 : roll < 40) begin
      // same bucket under the current divisor, different key
      return base + KEY_W'(effective_divisor() * $urandom_range(1, 4));
    end
    return KEY_W'($urandom);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("mismatch at %0t ns: %s", $time, what);
    end
  endtask

  // present one request, hold it until taken, then record what it must give
  task automatic send_request(input req_t op, input logic [KEY_W-1:0] k,
                              input logic [PAY_W-1:0] pay, input bit checked,
                              input table_result_t typed_result);
    int unsigned   gap;
    table_result_t predicted;
    gap = pick_gap(tx_steady);
    if (gap != 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= DATA_W'({pay, k});
    do @(posedge clk); while (!s_tready);
    // the predictor always advances so later rows see the right table
    predicted = hash_table_apply(op, k, pay);
    if (op == REQ_INSERT && predicted.status == ST_INSERTED) begin
      stored_keys.push_back(k);
    end
    if (checked) begin
      expected_results.push_back(typed_result);
    end else begin
      expected_results.push_back(predicted);
    end
  endtask

  // let the block go idle, then write a new bucket count
  task automatic write_bucket_count(input logic [BC_W-1:0] value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    bucket_count_reg = value;
  endtask

  // result side back-pressure, with steady stretches
  initial begin : result_stall
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (stall != 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) begin
          stall = pick_gap(1'b0);
        end
      end
    end
  end

  // every accepted result against the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, key %0h", m_tdata[30:0]));
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.status) begin
          report_mismatch($sformatf("key %0h status %0d, want %0d",
                                    want.key, m_tuser, want.status));
        end
        if (m_tdata[30:0] !== want.key) begin
          report_mismatch($sformatf("key_out %0h, want %0h", m_tdata[30:0], want.key));
        end
        if (m_tdata[94:31] !== want.payload) begin
          report_mismatch($sformatf("key %0h payload %0h, want %0h",
                                    want.key, m_tdata[94:31], want.payload));
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    table_result_t    typed;
    logic [BC_W-1:0]  phase_count [PHASES];
    req_t             op;
    logic [KEY_W-1:0] k;
    logic [PAY_W-1:0] pay;
    int unsigned      insert_odds;

    // predictor at reset: empty buckets, empty pool, count 13
    bucket_count_reg = BC_RESET;
    pool_used        = 0;
    for (int i = 0; i < BUCKETS; i++) begin
      chain_head[i] = NULL_PTR;
    end

    // zero and above-range counts, the range ends, the reset value, other in-range counts and a random one
    phase_count = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd5, 7'd65, 7'd13, 7'd2, 7'd33,
                    BC_W'($urandom_range(1, 63))};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part at the reset bucket count
    foreach (directed_rows[i]) begin
      typed.status  = directed_rows[i].exp_status;
      typed.key     = directed_rows[i].key;
      typed.payload = directed_rows[i].exp_payload;
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].payload,
                   directed_rows[i].checked, typed);
    end

    // random part, one bucket count per phase; the pool fills up in the last one
    for (int ph = 0; ph < PHASES; ph++) begin
      write_bucket_count(phase_count[ph]);
      insert_odds = (ph == PHASES - 1) ? 50 : 12;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        op  = ($urandom_range(0, 99) < insert_odds) ? REQ_INSERT : REQ_FIND;
        k   = pick_key(op == REQ_FIND);
        pay = {$urandom, $urandom};
        send_request(op, k, pay, 1'b0, typed);
      end
    end

    // drain, then allow for a full chain walk
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS chained_hash_table");
    end else begin
      $display("FAIL chained_hash_table");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin : run_limit
    #(30_000_000);
    $display("timeout, %0d results still pending", expected_results.size());
    $display("FAIL chained_hash_table");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/chash_pkg.sv
hw/rtl/chash_mod.sv
hw/rtl/chash_node_mem.sv
hw/rtl/chash_head_mem.sv
hw/rtl/chained_hash_table.sv
bench/tb_chained_hash_table.sv
